### rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, codes and the cell control bundle for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int ACT_W  = 3;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;
    localparam int FILL_W = 5;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PEEK_REAR  = 3'd5;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // One move order broadcast to every cell in a cycle.
    typedef struct packed {
        logic              shift_back;   // push front: every cell takes its front neighbor
        logic              shift_fwd;    // pop front: every cell takes its rear neighbor
        logic              load_rear;    // push rear: the cell at the current count loads
        logic [CNT_W-1:0]  count;        // entries held before this beat
        logic [BYTE_W-1:0] push_byte;
    } deq_ctrl_t;

endpackage

### rtl/core/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One queue slot: holds one byte and moves it with its neighbors.
// ----------------------------------------------------------------------------
module deq_cell
    import deq_pkg::*;
(
    input  logic              aclk,
    input  logic [IDX_W-1:0]  cell_idx,
    input  deq_ctrl_t         ctrl,
    input  logic [BYTE_W-1:0] front_data,   // neighbor toward the front (push byte for slot 0)
    input  logic [BYTE_W-1:0] rear_data,    // neighbor toward the rear
    output logic [BYTE_W-1:0] data
);

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;
    logic              is_tail;

    assign is_tail = (CNT_W'(cell_idx) == ctrl.count);

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_back) begin
            data_next = front_data;
        end else if (ctrl.shift_fwd) begin
            data_next = rear_data;
        end else if (ctrl.load_rear && is_tail) begin
            data_next = ctrl.push_byte;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded byte deque built as a row of shifting slots.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH bytes in a row of slots, slot 0 always being the
// front. A push at the front shifts every slot one place toward the rear, a pop
// at the front shifts every slot one place toward the front, a rear push writes
// only the slot at the current count and a rear pop moves no slot, so no pointer
// arithmetic is needed. Each accepted input beat gives exactly one result beat
// in the next cycle: the popped or peeked byte (zero otherwise), a status (done,
// empty, full) and the count after the action. The block takes one beat per
// cycle; the single output register stalls intake only while its result waits
// on m_tready. Slot contents need no reset: only slots that were pushed are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [2:0] action, [10:3] push_byte, [15:11] zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [7:0] out_byte, [9:8] status, [14:10] fill_count
);

    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] push_byte;
    logic              accept;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic [STAT_W-1:0] out_status_reg;
    logic [STAT_W-1:0] out_status_next;
    logic [FILL_W-1:0] out_fill_reg;
    logic [FILL_W-1:0] out_fill_next;

    logic              is_full;
    logic              is_empty;
    logic [IDX_W-1:0]  rear_idx;
    logic [BYTE_W-1:0] front_byte;
    logic [BYTE_W-1:0] rear_byte;

    deq_ctrl_t         ctrl;
    logic [BYTE_W-1:0] cell_data [DEPTH];

    assign action    = s_tdata[ACT_W-1:0];
    assign push_byte = s_tdata[ACT_W +: BYTE_W];

    // Take a new beat whenever the output register is free or draining now.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_full    = (count_reg == CNT_W'(DEPTH));
    assign is_empty   = (count_reg == '0);
    assign rear_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign front_byte = cell_data[0];
    assign rear_byte  = cell_data[rear_idx];

    // Decode the action into a slot move order and the result fields.
    always_comb begin
        ctrl            = '0;
        ctrl.count      = count_reg;
        ctrl.push_byte  = push_byte;
        count_next      = count_reg;
        out_byte_next   = '0;
        out_status_next = STAT_DONE;
        unique case (action) inside
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                if (is_full) begin
                    out_status_next = STAT_FULL;
                end else begin
                    ctrl.shift_back = accept && (action == ACT_PUSH_FRONT);
                    ctrl.load_rear  = accept && (action == ACT_PUSH_REAR);
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            ACT_POP_FRONT, ACT_PEEK_FRONT: begin
                if (is_empty) begin
                    out_status_next = STAT_EMPTY;
                end else begin
                    out_byte_next = front_byte;
                    if (action == ACT_POP_FRONT) begin
                        ctrl.shift_fwd = accept;
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
            end
            ACT_POP_REAR, ACT_PEEK_REAR: begin
                if (is_empty) begin
                    out_status_next = STAT_EMPTY;
                end else begin
                    out_byte_next = rear_byte;
                    if (action == ACT_POP_REAR) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                // Unused codes: leave everything alone.
            end
        endcase
        out_fill_next = FILL_W'(count_next);
    end

    // Row of slots: each takes a neighbor on a shift, a front push byte enters at slot 0.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [BYTE_W-1:0] from_front;
        logic [BYTE_W-1:0] from_rear;

        if (i == 0) begin : g_head
            assign from_front = push_byte;
        end else begin : g_mid
            assign from_front = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign from_rear = cell_data[i];
        end else begin : g_body
            assign from_rear = cell_data[i+1];
        end

        deq_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (IDX_W'(i)),
            .ctrl       (ctrl),
            .front_data (from_front),
            .rear_data  (from_rear),
            .data       (cell_data[i])
        );
    end

    // Hold the result until the sink takes it.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_byte_reg   <= out_byte_next;
            out_status_reg <= out_status_next;
            out_fill_reg   <= out_fill_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - BYTE_W - STAT_W - FILL_W){1'b0}},
                       out_fill_reg, out_status_reg, out_byte_reg};

    // Count never passes capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("count above capacity");

    // A push into a full queue reports full and leaves the count alone.
    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_full && (action == ACT_PUSH_FRONT || action == ACT_PUSH_REAR)
        |=> out_status_reg == STAT_FULL && count_reg == $past(count_reg))
        else $error("full push changed state");

    // A pop on a non-empty queue drops exactly one entry.
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_empty && (action == ACT_POP_FRONT || action == ACT_POP_REAR)
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not drop one entry");

    // Every accepted beat shows a result next cycle, carrying the new count.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid && out_fill_reg == FILL_W'(count_reg))
        else $error("missing or stale result");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the bounded byte deque.
// ----------------------------------------------------------------------------
// Drives actions into the slave channel and follows every accepted beat with
// a behavioral model of the deque (ring of slots, front index, count). Each
// result beat is compared field by field against the oldest expected result.
// A short directed sequence covers the empty and full edges, both ends and the
// spare action codes. A long random sequence follows, with fill and drain
// phases so that both edges are reached many times. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import deq_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_ITEMS  = 100;

    // spare action codes: the block must answer them without touching state
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [STAT_W-1:0] status;
        logic [FILL_W-1:0] fill_count;
    } deq_result_t;

    // Behavioral deque plus the queue of results it still owes.
    class deque_tracker;
        logic [BYTE_W-1:0] slots [DEPTH];
        int                front;
        int                held;
        deq_result_t       pending [$];
        int                fail_count;

        function new();
            front      = 0;
            held       = 0;
            fail_count = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        function void note_action(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] value);
            deq_result_t r;
            int          slot;
            r.out_byte = '0;
            r.status   = STAT_DONE;
            case (act)
                ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                    if (held >= DEPTH) begin
                        r.status = STAT_FULL;
                    end else if (act == ACT_PUSH_FRONT) begin
                        front        = (front + DEPTH - 1) % DEPTH;
                        slots[front] = value;
                        held++;
                    end else begin
                        slots[(front + held) % DEPTH] = value;
                        held++;
                    end
                end
                ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
                    if (held == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        slot = (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT) ?
                               front : (front + held - 1) % DEPTH;
                        r.out_byte = slots[slot];
                        if (act == ACT_POP_FRONT) begin
                            front = (front + 1) % DEPTH;
                            held--;
                        end else if (act == ACT_POP_REAR) begin
                            held--;
                        end
                    end
                end
                default: ;
            endcase
            r.fill_count = FILL_W'(held);
            pending.push_back(r);
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] beat);
            deq_result_t want;
            deq_result_t got;
            got.out_byte   = beat[BYTE_W-1:0];
            got.status     = beat[BYTE_W +: STAT_W];
            got.fill_count = beat[BYTE_W+STAT_W +: FILL_W];
            if (pending.size() == 0) begin
                flag($sformatf("unexpected result beat %h", beat));
                return;
            end
            want = pending.pop_front();
            if (got.out_byte !== want.out_byte)
                flag($sformatf("out_byte expected %h got %h", want.out_byte, got.out_byte));
            if (got.status !== want.status)
                flag($sformatf("status expected %0d got %0d", want.status, got.status));
            if (got.fill_count !== want.fill_count)
                flag($sformatf("fill_count expected %0d got %0d",
                               want.fill_count, got.fill_count));
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [2:0] action, [10:3] push_byte, [15:11] zero
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [7:0] out_byte, [9:8] status, [14:10] fill_count

    deque_tracker tracker = new();

    // gaps_on enables random idling for the current stretch; quiet_tail
    // shuts it off for the closing part of the run
    bit gaps_on;
    bit quiet_tail;
    bit fill_mode;

    double_ended_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Hold valid low for a burst, if idling is on for this stretch.
    task automatic maybe_gap();
        int len;
        if (gaps_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
            len = $urandom_range(1, 12);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (len - 1) @(negedge aclk);
        end
    endtask

    // Present one action beat and hold it until the block takes it.
    task automatic send_action(logic [ACT_W-1:0] act, logic [BYTE_W-1:0] value);
        maybe_gap();
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-ACT_W-BYTE_W){1'b0}}, value, act};
        do @(posedge aclk); while (!s_tready);
        tracker.note_action(act, value);
    endtask

    // Pick the next random action: fill phases lean on pushes, drain phases
    // on pops, so the queue swings between empty and full again and again.
    function automatic logic [ACT_W-1:0] pick_action();
        int              roll;
        logic [ACT_W-1:0] push_act;
        logic [ACT_W-1:0] pop_act;
        if (tracker.held == DEPTH && $urandom_range(0, 1) == 1) fill_mode = 1'b0;
        else if (tracker.held == 0 && $urandom_range(0, 1) == 1) fill_mode = 1'b1;
        else if ($urandom_range(0, 39) == 0) fill_mode = !fill_mode;
        push_act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        pop_act  = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
        roll     = $urandom_range(0, 99);
        if (roll < 2)
            return $urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI;
        if (roll < 20)
            return $urandom_range(0, 1) ? ACT_PEEK_FRONT : ACT_PEEK_REAR;
        if (roll < 72)
            return fill_mode ? push_act : pop_act;
        return fill_mode ? pop_act : push_act;
    endfunction

    // Result side: accept beats, stalling in random bursts.
    initial begin : result_sink
        int len;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (gaps_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
                len = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (len - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Sample every accepted result beat at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata);
    end

    initial begin : stimulus
        int i;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        gaps_on    = 1'b1;
        quiet_tail = 1'b0;
        fill_mode  = 1'b1;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty queue: every read action reports empty
        send_action(ACT_PEEK_FRONT, 8'h00);
        send_action(ACT_POP_FRONT,  8'hFF);
        send_action(ACT_POP_REAR,   8'h00);
        send_action(ACT_PEEK_REAR,  8'hFF);
        // spare codes leave everything alone
        send_action(ACT_SPARE_LO, 8'hA5);
        send_action(ACT_SPARE_HI, 8'h5A);
        // fill from both ends, extreme bytes first
        send_action(ACT_PUSH_FRONT, 8'h00);
        send_action(ACT_PUSH_REAR,  8'hFF);
        for (i = 2; i < DEPTH; i++)
            send_action((i % 2) ? ACT_PUSH_FRONT : ACT_PUSH_REAR, 8'(i * 17 + 3));
        // full queue: pushes at either end are refused
        send_action(ACT_PUSH_FRONT, 8'hFF);
        send_action(ACT_PUSH_REAR,  8'h00);
        send_action(ACT_PEEK_FRONT, 8'h00);
        send_action(ACT_PEEK_REAR,  8'h00);
        send_action(ACT_POP_FRONT,  8'h00);
        send_action(ACT_POP_REAR,   8'h00);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if (i >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
            send_action(pick_action(), 8'($urandom_range(0, 255)));
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain the outstanding results, then allow a few spare cycles
        while (tracker.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (tracker.fail_count == 0 && tracker.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/double_ended_queue.sv
bench/testbench.sv
